>>> rtl/core/elffa_pkg.sv
// Shared types, constants and helpers for the explicit-list first-fit allocator.
// No dependencies; the sequencer and the top level import this package.
`timescale 1ns / 1ps
`default_nettype none
package elffa_pkg;

  localparam int HEAP_SIZE  = 4096;
  localparam int HEAP_WORDS = HEAP_SIZE / 8;
  localparam int BW         = $clog2(HEAP_SIZE);
  localparam int AW         = $clog2(HEAP_WORDS);
  localparam int LW         = $clog2(HEAP_SIZE + 3);
  localparam int XW         = LW + 2;
  localparam int CNT_W      = $clog2(HEAP_SIZE / 40 + 1);
  localparam int OVERHEAD   = 40;
  localparam int HEAD_BYTES = 32;

  typedef logic [LW-1:0] word_t;
  typedef logic [XW-1:0] wide_t;

  localparam word_t LINK_BEGIN = word_t'(HEAP_SIZE + 1);
  localparam word_t LINK_END   = word_t'(HEAP_SIZE + 2);
  localparam word_t ST_FREE    = word_t'(1);
  localparam word_t ST_USED    = word_t'(2);

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NO_FIT   = 2'd1;
  localparam logic [1:0] STATUS_IGNORED  = 2'd2;
  localparam logic [1:0] STATUS_BAD_SIZE = 2'd3;

  typedef struct packed {
    logic        func;
    logic [12:0] request_bytes;
    logic [11:0] free_address;
  } el_cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] user_address;
    logic [6:0]  free_block_count;
    logic [12:0] free_byte_total;
    logic [6:0]  used_block_count;
    logic [12:0] used_byte_total;
  } el_result_t;

  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    word_t         wdata;
    logic [AW-1:0] raddr;
  } mem_req_t;

  function automatic logic is_addr(word_t x);
    return x < word_t'(HEAP_SIZE);
  endfunction

  function automatic logic [AW-1:0] word_at(wide_t off);
    return off[BW-1:3];
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/elffa_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module elffa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> rtl/core/elffa_seq.sv
// Allocator sequencer: walks lists, splits, relinks and merges blocks in the heap RAM.
// Depends on elffa_pkg; drives the RAM through a mem_req_t and reads its registered data.
`timescale 1ns / 1ps
`default_nettype none
module elffa_seq import elffa_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  el_cmd_t    cmd,
  output logic       done,
  output el_result_t result,
  output mem_req_t   mem_req,
  input  word_t      rdata
);

  localparam logic [5:0] S_IDLE  = 6'd0;
  localparam logic [5:0] S_A_CHK = 6'd1;
  localparam logic [5:0] S_A_SZ  = 6'd2;
  localparam logic [5:0] S_A_NXT = 6'd3;
  localparam logic [5:0] S_A_W0  = 6'd4;
  localparam logic [5:0] S_A_W1  = 6'd5;
  localparam logic [5:0] S_A_W2  = 6'd6;
  localparam logic [5:0] S_A_W3  = 6'd7;
  localparam logic [5:0] S_A_W4  = 6'd8;
  localparam logic [5:0] S_A_W5  = 6'd9;
  localparam logic [5:0] S_A_FIN = 6'd10;
  localparam logic [5:0] S_F_CHK = 6'd11;
  localparam logic [5:0] S_F_NXT = 6'd12;
  localparam logic [5:0] S_F_BL  = 6'd13;
  localparam logic [5:0] S_F_BL2 = 6'd14;
  localparam logic [5:0] S_F_SZ  = 6'd15;
  localparam logic [5:0] S_F_SZ2 = 6'd16;
  localparam logic [5:0] S_F_ST  = 6'd17;
  localparam logic [5:0] S_M0    = 6'd18;
  localparam logic [5:0] S_M1    = 6'd19;
  localparam logic [5:0] S_M2    = 6'd20;
  localparam logic [5:0] S_M3    = 6'd21;
  localparam logic [5:0] S_M4    = 6'd22;
  localparam logic [5:0] S_M5    = 6'd23;
  localparam logic [5:0] S_M6    = 6'd24;
  localparam logic [5:0] S_M7    = 6'd25;
  localparam logic [5:0] S_M_END = 6'd26;
  localparam logic [5:0] S_U0    = 6'd27;
  localparam logic [5:0] S_U1    = 6'd28;
  localparam logic [5:0] S_U2    = 6'd29;
  localparam logic [5:0] S_U3    = 6'd30;
  localparam logic [5:0] S_P0    = 6'd31;
  localparam logic [5:0] S_P1    = 6'd32;
  localparam logic [5:0] S_P2    = 6'd33;

  localparam logic L_FREE = 1'b0;
  localparam logic L_USED = 1'b1;

  logic [5:0] st;
  logic [5:0] ret;

  word_t             first [2];
  word_t             last  [2];
  logic [CNT_W-1:0]  count [2];
  word_t             bytes [2];

  word_t       b, blk, sec, rest, szf, below, lo, above, sl, sa;
  word_t       cur, ssz, p_r, n_r;
  logic        lsel, pass2;
  logic [12:0] req_r;

  wide_t       ab;
  word_t       ns;
  logic        fin;
  logic [1:0]  fin_status;
  logic [11:0] fin_uaddr;

  assign busy = (st != S_IDLE);
  assign ab   = wide_t'(lo) + wide_t'(rdata) + wide_t'(OVERHEAD);
  assign ns   = word_t'(wide_t'(sl) + wide_t'(sa) + wide_t'(OVERHEAD));

  always_comb begin
    mem_req    = '0;
    fin        = 1'b0;
    fin_status = STATUS_OK;
    fin_uaddr  = '0;
    unique case (st)
      S_IDLE: begin
        if (start) begin
          if (cmd.func == FUNC_ALLOC) begin
            if (cmd.request_bytes[2:0] != 3'd0) begin
              fin        = 1'b1;
              fin_status = STATUS_BAD_SIZE;
            end
          end else if (cmd.free_address < 12'(HEAD_BYTES)) begin
            fin        = 1'b1;
            fin_status = STATUS_IGNORED;
          end
        end
      end
      S_A_CHK: begin
        mem_req.raddr = word_at(wide_t'(b));
        if (!is_addr(b)) begin
          fin        = 1'b1;
          fin_status = STATUS_NO_FIT;
        end
      end
      S_A_SZ: mem_req.raddr = word_at(wide_t'(b) + wide_t'(16));
      S_A_W0: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = word_at(wide_t'(blk));
        mem_req.wdata = word_t'(req_r);
      end
      S_A_W1: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = word_at(wide_t'(blk) + wide_t'(HEAD_BYTES) + wide_t'(req_r));
        mem_req.wdata = word_t'(req_r);
      end
      S_A_W2: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = word_at(wide_t'(sec));
        mem_req.wdata = rest;
      end
      S_A_W3: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = word_at(wide_t'(sec) + wide_t'(HEAD_BYTES) + wide_t'(rest));
        mem_req.wdata = rest;
      end
      S_A_W4: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = word_at(wide_t'(blk) + wide_t'(8));
        mem_req.wdata = ST_USED;
      end
      S_A_W5: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = word_at(wide_t'(sec) + wide_t'(8));
        mem_req.wdata = ST_FREE;
      end
      S_A_FIN: begin
        fin       = 1'b1;
        fin_uaddr = 12'(wide_t'(blk) + wide_t'(HEAD_BYTES));
      end
      S_F_CHK: begin
        mem_req.raddr = word_at(wide_t'(b) + wide_t'(16));
        if (!is_addr(b)) begin
          fin        = 1'b1;
          fin_status = STATUS_IGNORED;
        end
      end
      S_F_BL:  mem_req.raddr = word_at(wide_t'(blk) - wide_t'(8));
      S_F_SZ:  mem_req.raddr = word_at(wide_t'(blk));
      S_F_ST: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = word_at(wide_t'(blk) + wide_t'(8));
        mem_req.wdata = ST_FREE;
      end
      S_M0: mem_req.raddr = word_at(wide_t'(lo) + wide_t'(8));
      S_M1: mem_req.raddr = word_at(wide_t'(lo));
      S_M2: mem_req.raddr = word_at(ab + wide_t'(8));
      S_M3: mem_req.raddr = word_at(wide_t'(above));
      S_M6: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = word_at(wide_t'(lo));
        mem_req.wdata = ns;
      end
      S_M7: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = word_at(wide_t'(above) + wide_t'(HEAD_BYTES) + wide_t'(sa));
        mem_req.wdata = ns;
      end
      S_M_END: begin
        if (pass2 || !is_addr(below)) begin
          fin = 1'b1;
        end
      end
      S_U0: mem_req.raddr = word_at(wide_t'(cur) + wide_t'(24));
      S_U1: mem_req.raddr = word_at(wide_t'(cur) + wide_t'(16));
      S_U2: begin
        mem_req.we    = is_addr(p_r);
        mem_req.waddr = word_at(wide_t'(p_r) + wide_t'(16));
        mem_req.wdata = rdata;
      end
      S_U3: begin
        mem_req.we    = is_addr(n_r);
        mem_req.waddr = word_at(wide_t'(n_r) + wide_t'(24));
        mem_req.wdata = p_r;
      end
      S_P0: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = word_at(wide_t'(cur) + wide_t'(24));
        mem_req.wdata = LINK_BEGIN;
      end
      S_P1: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = word_at(wide_t'(cur) + wide_t'(16));
        mem_req.wdata = first[lsel];
      end
      S_P2: begin
        mem_req.we    = is_addr(first[lsel]);
        mem_req.waddr = word_at(wide_t'(first[lsel]) + wide_t'(24));
        mem_req.wdata = cur;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    done <= fin;
    if (fin) begin
      result.status           <= fin_status;
      result.user_address     <= fin_uaddr;
      result.free_block_count <= 7'(count[L_FREE]);
      result.free_byte_total  <= 13'(bytes[L_FREE]);
      result.used_block_count <= 7'(count[L_USED]);
      result.used_byte_total  <= 13'(bytes[L_USED]);
    end
    if (rst) begin
      st            <= S_IDLE;
      done          <= 1'b0;
      first[L_FREE] <= '0;
      last[L_FREE]  <= '0;
      count[L_FREE] <= CNT_W'(1);
      bytes[L_FREE] <= word_t'(HEAP_SIZE);
      first[L_USED] <= LINK_END;
      last[L_USED]  <= LINK_BEGIN;
      count[L_USED] <= '0;
      bytes[L_USED] <= '0;
    end else begin
      unique case (st)
        S_IDLE: begin
          if (start && !fin) begin
            req_r <= cmd.request_bytes;
            pass2 <= 1'b0;
            if (cmd.func == FUNC_ALLOC) begin
              b  <= first[L_FREE];
              st <= S_A_CHK;
            end else begin
              blk <= word_t'(cmd.free_address - 12'(HEAD_BYTES));
              b   <= first[L_USED];
              st  <= S_F_CHK;
            end
          end
        end
        S_A_CHK: st <= fin ? S_IDLE : S_A_SZ;
        S_A_SZ: begin
          if (wide_t'(rdata) >= wide_t'(req_r) + wide_t'(OVERHEAD)) begin
            blk  <= b;
            szf  <= rdata;
            sec  <= word_t'(wide_t'(b) + wide_t'(req_r) + wide_t'(OVERHEAD));
            rest <= word_t'(wide_t'(rdata) - wide_t'(req_r) - wide_t'(OVERHEAD));
            cur  <= b;
            lsel <= L_FREE;
            ssz  <= rdata;
            ret  <= S_A_W0;
            st   <= S_U0;
          end else begin
            st <= S_A_NXT;
          end
        end
        S_A_NXT: begin
          b  <= rdata;
          st <= S_A_CHK;
        end
        S_A_W0: st <= S_A_W1;
        S_A_W1: st <= S_A_W2;
        S_A_W2: st <= S_A_W3;
        S_A_W3: st <= S_A_W4;
        S_A_W4: begin
          cur  <= blk;
          lsel <= L_USED;
          ssz  <= word_t'(req_r);
          ret  <= S_A_W5;
          st   <= S_P0;
        end
        S_A_W5: begin
          cur  <= sec;
          lsel <= L_FREE;
          ssz  <= rest;
          ret  <= S_A_FIN;
          st   <= S_P0;
        end
        S_A_FIN: st <= S_IDLE;
        S_F_CHK: begin
          if (fin) begin
            st <= S_IDLE;
          end else if (b == blk) begin
            st <= S_F_BL;
          end else begin
            st <= S_F_NXT;
          end
        end
        S_F_NXT: begin
          b  <= rdata;
          st <= S_F_CHK;
        end
        S_F_BL: begin
          if (blk >= word_t'(8)) begin
            st <= S_F_BL2;
          end else begin
            below <= LINK_END;
            st    <= S_F_SZ;
          end
        end
        S_F_BL2: begin
          if (wide_t'(rdata) + wide_t'(OVERHEAD) <= wide_t'(blk)) begin
            below <= word_t'(wide_t'(blk) - wide_t'(rdata) - wide_t'(OVERHEAD));
          end else begin
            below <= LINK_END;
          end
          st <= S_F_SZ;
        end
        S_F_SZ: st <= S_F_SZ2;
        S_F_SZ2: begin
          szf  <= rdata;
          cur  <= blk;
          lsel <= L_USED;
          ssz  <= rdata;
          ret  <= S_F_ST;
          st   <= S_U0;
        end
        S_F_ST: begin
          lo   <= blk;
          cur  <= blk;
          lsel <= L_FREE;
          ssz  <= szf;
          ret  <= S_M0;
          st   <= S_P0;
        end
        S_M0: st <= S_M1;
        S_M1: st <= (rdata != ST_FREE) ? S_M_END : S_M2;
        S_M2: begin
          sl    <= rdata;
          above <= word_t'(ab);
          st    <= (ab >= wide_t'(HEAP_SIZE)) ? S_M_END : S_M3;
        end
        S_M3: st <= (rdata != ST_FREE) ? S_M_END : S_M4;
        S_M4: begin
          sa   <= rdata;
          cur  <= above;
          lsel <= L_FREE;
          ssz  <= rdata;
          ret  <= S_M5;
          st   <= S_U0;
        end
        S_M5: begin
          cur  <= lo;
          lsel <= L_FREE;
          ssz  <= sl;
          ret  <= S_M6;
          st   <= S_U0;
        end
        S_M6: st <= S_M7;
        S_M7: begin
          cur  <= lo;
          lsel <= L_FREE;
          ssz  <= ns;
          ret  <= S_M_END;
          st   <= S_P0;
        end
        S_M_END: begin
          if (fin) begin
            st <= S_IDLE;
          end else begin
            pass2 <= 1'b1;
            lo    <= below;
            st    <= S_M0;
          end
        end
        S_U0: st <= S_U1;
        S_U1: begin
          p_r <= rdata;
          st  <= S_U2;
        end
        S_U2: begin
          n_r <= rdata;
          if (!is_addr(p_r)) begin
            first[lsel] <= rdata;
          end
          st <= S_U3;
        end
        S_U3: begin
          if (!is_addr(n_r)) begin
            last[lsel] <= p_r;
          end
          count[lsel] <= count[lsel] - CNT_W'(1);
          bytes[lsel] <= bytes[lsel] - word_t'(OVERHEAD) - ssz;
          st          <= ret;
        end
        S_P0: st <= S_P1;
        S_P1: st <= S_P2;
        S_P2: begin
          if (!is_addr(first[lsel])) begin
            last[lsel] <= cur;
          end
          first[lsel] <= cur;
          count[lsel] <= count[lsel] + CNT_W'(1);
          bytes[lsel] <= bytes[lsel] + word_t'(OVERHEAD) + ssz;
          st          <= ret;
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  // Between items the two lists together always account for the whole heap.
  a_bytes_conserved: assert property (@(posedge clk) disable iff (rst)
    (st == S_IDLE) |-> (wide_t'(bytes[L_FREE]) + wide_t'(bytes[L_USED])
                        == wide_t'(HEAP_SIZE)))
    else $error("free and used byte totals do not cover the heap");

  // Every allocation leaves a remainder and every free adds a block.
  a_free_nonempty: assert property (@(posedge clk) disable iff (rst)
    (st == S_IDLE) |-> (count[L_FREE] != '0))
    else $error("free list empty between items");

  // An accepted item is either still at work or finished at once.
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted item neither in progress nor answered");

endmodule
`default_nettype wire

>>> rtl/core/explicit_list_first_fit_allocator.sv
// Top level of the explicit-list first-fit heap allocator: reset clearing pass,
// heap RAM and sequencer. Depends on elffa_pkg, elffa_ram and elffa_seq.
`timescale 1ns / 1ps
`default_nettype none
// The block manages a 4096-byte heap held in a 512 x 13-bit RAM. An item is
// taken when start is high and busy is low; its single result appears on
// result for exactly one cycle with done high, and the receiver cannot hold it
// off, so it must capture it in that cycle. After reset the block is busy while
// it sweeps the whole RAM, zeroing it and laying down the one free block that
// spans the heap. An allocate walks the free list first fit, checking each
// block's size, unlinks the chosen block, writes the sizes and status of the
// used block and the remainder, and puts each at the head of its list. A free
// walks the used list to find the block, moves it to the free list, then tries
// the two neighbor merges. A bad size or an address below the first user offset
// is answered at once. Results with a non-zero status leave the heap untouched.
module explicit_list_first_fit_allocator import elffa_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  el_cmd_t    cmd,
  output logic       done,
  output el_result_t result
);

  logic          clearing;
  logic [AW-1:0] clr_idx;
  logic          seq_busy;
  mem_req_t      seq_req;
  mem_req_t      ram_req;
  word_t         rdata;

  // Contents of the heap right after reset: a single free block whose header
  // sits in the first four words and whose footer is the last word.
  function automatic word_t init_word(logic [AW-1:0] idx);
    word_t v;
    v = '0;
    priority if (idx == AW'(0)) begin
      v = word_t'(HEAP_SIZE - OVERHEAD);
    end else if (idx == AW'(1)) begin
      v = ST_FREE;
    end else if (idx == AW'(2)) begin
      v = LINK_END;
    end else if (idx == AW'(3)) begin
      v = LINK_BEGIN;
    end else if (idx == AW'(HEAP_WORDS - 1)) begin
      v = word_t'(HEAP_SIZE - OVERHEAD);
    end
    return v;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      clr_idx <= clr_idx + AW'(1);
      if (clr_idx == AW'(HEAP_WORDS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // The clearing pass owns the write port until it finishes; the sequencer
  // is held idle meanwhile, so the two never contend.
  always_comb begin
    if (clearing) begin
      ram_req.we    = 1'b1;
      ram_req.waddr = clr_idx;
      ram_req.wdata = init_word(clr_idx);
      ram_req.raddr = '0;
    end else begin
      ram_req = seq_req;
    end
  end

  assign busy = clearing | seq_busy;

  elffa_ram #(
    .WIDTH(LW),
    .DEPTH(HEAP_WORDS)
  ) u_heap (
    .clk  (clk),
    .we   (ram_req.we),
    .waddr(ram_req.waddr),
    .wdata(ram_req.wdata),
    .raddr(ram_req.raddr),
    .rdata(rdata)
  );

  elffa_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (start & ~clearing),
    .busy   (seq_busy),
    .cmd    (cmd),
    .done   (done),
    .result (result),
    .mem_req(seq_req),
    .rdata  (rdata)
  );

endmodule
`default_nettype wire
